FILE: design/assert_macros.svh
// assertion macros used by the response checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

FILE: design/mbrc_pkg.sv
// shared constants, types and the crc step for the modbus response checker
package mbrc_pkg;

  localparam int MAX_LEN     = 64;
  localparam int CNT_W       = $clog2(MAX_LEN + 1);
  localparam int FRAME_LEN_W = 7;
  localparam int WORD_W      = 32;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [7:0]  STATION_ID_RST = 8'h01;
  localparam logic [7:0]  BROADCAST_ADDR = 8'h00;

  // register index decoded from paddr[2]
  localparam logic REG_STATION_ID = 1'b0;

  typedef enum logic {
    ACT_BYTE = 1'b0,
    ACT_IDLE = 1'b1
  } action_t;

  typedef struct packed {
    logic [CNT_W-1:0]  byte_count;
    logic [15:0]       crc_lag_two;
    logic [7:0]        prev_byte;
    logic [7:0]        last_byte;
    logic [7:0]        first_byte;
    logic [WORD_W-1:0] voltage_bytes;
    logic [WORD_W-1:0] current_bytes;
  } frame_status_t;

  // one byte of reflected crc-16, eight shift steps
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

FILE: design/mbrc_channels.sv
// handshake channels for received bytes and frame results
interface mbrc_in_if import mbrc_pkg::*; ();
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] rx_byte;

  modport source (output valid, output action, output rx_byte, input ready);
  modport sink   (input valid, input action, input rx_byte, output ready);
endinterface

interface mbrc_out_if import mbrc_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [FRAME_LEN_W-1:0] frame_length;
  logic                   address_ok;
  logic                   check_ok;
  logic                   frame_accepted;
  logic [WORD_W-1:0]      voltage_word;
  logic [WORD_W-1:0]      current_word;

  modport source (output valid, output frame_length, output address_ok, output check_ok,
                  output frame_accepted, output voltage_word, output current_word,
                  input ready);
  modport sink   (input valid, input frame_length, input address_ok, input check_ok,
                  input frame_accepted, input voltage_word, input current_word,
                  output ready);
endinterface

FILE: design/mbrc_frame_acc.sv
// per-frame accumulator: byte count, running crc with history, captured bytes
module mbrc_frame_acc import mbrc_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          byte_en,
  input  logic          restart,
  input  logic [7:0]    rx_byte,
  output frame_status_t status
);

  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [15:0]       crc_r, crc_nxt;
  logic [15:0]       lag1_r, lag1_nxt;
  logic [15:0]       lag2_r, lag2_nxt;
  logic [7:0]        prev_r, prev_nxt;
  logic [7:0]        last_r, last_nxt;
  logic [7:0]        first_r, first_nxt;
  logic [WORD_W-1:0] volt_r, volt_nxt;
  logic [WORD_W-1:0] curr_r, curr_nxt;
  logic              store;

  // bytes past the cap are dropped
  assign store = byte_en && (count_r < CNT_W'(MAX_LEN));

  always_comb begin
    count_nxt = count_r;
    crc_nxt   = crc_r;
    lag1_nxt  = lag1_r;
    lag2_nxt  = lag2_r;
    prev_nxt  = prev_r;
    last_nxt  = last_r;
    first_nxt = first_r;
    volt_nxt  = volt_r;
    curr_nxt  = curr_r;
    if (restart) begin
      count_nxt = '0;
      crc_nxt   = CRC_INIT;
      lag1_nxt  = CRC_INIT;
      lag2_nxt  = CRC_INIT;
      prev_nxt  = '0;
      last_nxt  = '0;
      first_nxt = '0;
      volt_nxt  = '0;
      curr_nxt  = '0;
    end else if (store) begin
      count_nxt = count_r + CNT_W'(1);
      crc_nxt   = crc_byte(crc_r, rx_byte);
      lag1_nxt  = crc_r;
      lag2_nxt  = lag1_r;
      prev_nxt  = last_r;
      last_nxt  = rx_byte;
      if (count_r == '0) begin
        first_nxt = rx_byte;
      end
      // bytes 3..6 and 7..10 land big-endian
      for (int i = 0; i < 4; i++) begin
        if (count_r == CNT_W'(3 + i)) begin
          volt_nxt[8*(3-i) +: 8] = rx_byte;
        end
        if (count_r == CNT_W'(7 + i)) begin
          curr_nxt[8*(3-i) +: 8] = rx_byte;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      crc_r   <= CRC_INIT;
      lag1_r  <= CRC_INIT;
      lag2_r  <= CRC_INIT;
      prev_r  <= '0;
      last_r  <= '0;
      first_r <= '0;
      volt_r  <= '0;
      curr_r  <= '0;
    end else begin
      count_r <= count_nxt;
      crc_r   <= crc_nxt;
      lag1_r  <= lag1_nxt;
      lag2_r  <= lag2_nxt;
      prev_r  <= prev_nxt;
      last_r  <= last_nxt;
      first_r <= first_nxt;
      volt_r  <= volt_nxt;
      curr_r  <= curr_nxt;
    end
  end

  assign status.byte_count    = count_r;
  assign status.crc_lag_two   = lag2_r;
  assign status.prev_byte     = prev_r;
  assign status.last_byte     = last_r;
  assign status.first_byte    = first_r;
  assign status.voltage_bytes = volt_r;
  assign status.current_bytes = curr_r;

endmodule

FILE: design/modbus_rtu_response_checker.sv
// Modbus RTU response checker: takes received bytes and line-idle markers one
// transaction per clock and gives one result transaction per idle marker. Each
// input transaction is first captured in an input register; on the next cycle
// a byte updates the frame state (count, CRC-16 with two bytes of history,
// first byte, last two bytes, voltage and current bytes) through one unrolled
// 8-bit CRC step, and an idle marker is turned into a result in the output
// register once the output register has room. A result thus passes through
// the input register and then the output register before it can be taken.
// Throughput is one transaction per cycle; an idle marker only waits in the
// input register while the previous result is still held in the output
// register. Bytes beyond MAX_LEN in a frame are dropped. station_id lies at
// APB address 0 and should only be written while no frame is in progress.
`include "assert_macros.svh"

module modbus_rtu_response_checker import mbrc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  mbrc_in_if.sink               in_ch,
  mbrc_out_if.source            out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  // configuration register
  logic [7:0] station_r;
  logic       cfg_wr;

  // input stage
  logic       stg_valid_r;
  logic       stg_action_r;
  logic [7:0] stg_byte_r;
  logic       stg_go;
  logic       stg_idle;
  logic       in_fire;

  // frame state
  frame_status_t fs;

  // result computation
  logic addr_ok, chk_ok, acc_ok;

  // output register
  logic                   out_valid_r;
  logic [FRAME_LEN_W-1:0] len_r;
  logic                   addr_ok_r;
  logic                   chk_ok_r;
  logic                   acc_ok_r;
  logic [WORD_W-1:0]      volt_r;
  logic [WORD_W-1:0]      curr_r;

  // apb: zero-wait writes, register select on the word address bit
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_STATION_ID);
  assign prdata = (paddr[2] == REG_STATION_ID) ? {24'h000000, station_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      station_r <= STATION_ID_RST;
    end else if (cfg_wr) begin
      station_r <= pwdata[7:0];
    end
  end

  // a byte always moves on; an idle marker needs room in the output register
  assign stg_idle = (stg_action_r == ACT_IDLE);
  assign stg_go   = stg_valid_r && (!stg_idle || !out_valid_r || out_ch.ready);
  assign in_ch.ready = !stg_valid_r || stg_go;
  assign in_fire  = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (in_fire) begin
      stg_valid_r <= 1'b1;
    end else if (stg_go) begin
      stg_valid_r <= 1'b0;
    end
  end

  // payload of the input stage, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      stg_action_r <= in_ch.action;
      stg_byte_r   <= in_ch.rx_byte;
    end
  end

  mbrc_frame_acc u_acc (
    .clk     (clk),
    .rst_n   (rst_n),
    .byte_en (stg_go && !stg_idle),
    .restart (stg_go && stg_idle),
    .rx_byte (stg_byte_r),
    .status  (fs)
  );

  // address matches this station or broadcast, only if a first byte exists
  assign addr_ok = (fs.byte_count != '0) &&
                   ((fs.first_byte == station_r) || (fs.first_byte == BROADCAST_ADDR));
  // trailing two bytes must equal the crc taken before them, low byte first
  assign chk_ok  = (fs.byte_count >= CNT_W'(2)) &&
                   (fs.prev_byte == fs.crc_lag_two[7:0]) &&
                   (fs.last_byte == fs.crc_lag_two[15:8]);
  assign acc_ok  = addr_ok && chk_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (stg_go && stg_idle) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload, loaded when an idle marker completes
  always_ff @(posedge clk) begin
    if (stg_go && stg_idle) begin
      len_r     <= FRAME_LEN_W'(fs.byte_count);
      addr_ok_r <= addr_ok;
      chk_ok_r  <= chk_ok;
      acc_ok_r  <= acc_ok;
      volt_r    <= acc_ok ? fs.voltage_bytes : '0;
      curr_r    <= acc_ok ? fs.current_bytes : '0;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.frame_length   = len_r;
  assign out_ch.address_ok     = addr_ok_r;
  assign out_ch.check_ok       = chk_ok_r;
  assign out_ch.frame_accepted = acc_ok_r;
  assign out_ch.voltage_word   = volt_r;
  assign out_ch.current_word   = curr_r;

  // a rejected frame never exposes its data words
  `ASSERT_IMPL(a_rejected_words_zero, clk, rst_n, out_valid_r && !acc_ok_r, (volt_r == '0) && (curr_r == '0))
  // every idle marker leaves the next frame starting from scratch
  `ASSERT_NEXT(a_restart_after_idle, clk, rst_n, stg_go && stg_idle, (fs.byte_count == '0) && (fs.crc_lag_two == CRC_INIT))
  // stored byte count never passes the cap
  `ASSERT_IMPL(a_count_capped, clk, rst_n, 1'b1, fs.byte_count <= CNT_W'(MAX_LEN))

endmodule

FILE: bench/testbench.sv
// self-checking testbench for the modbus rtu response checker, frame-level prediction
`timescale 1ns / 100ps

module testbench;
  import mbrc_pkg::*;

  // run limits and idle tail after each phase
  localparam int CYCLE_LIMIT   = 600000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_ITEMS   = 220;

  typedef logic [7:0] byte_q_t[$];

  // one pending input transaction
  typedef struct packed {
    action_t    act;
    logic [7:0] data;
  } rx_item_t;

  // one expected result transaction
  typedef struct packed {
    logic [FRAME_LEN_W-1:0] length;
    logic                   addr_ok;
    logic                   crc_ok;
    logic                   accepted;
    logic [WORD_W-1:0]      voltage;
    logic [WORD_W-1:0]      current;
  } frame_result_t;

  logic clk = 1'b0;
  logic rst_n;

  // apb configuration port
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  mbrc_in_if  in_ch ();
  mbrc_out_if out_ch ();

  modbus_rtu_response_checker dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // stimulus and expectation stores
  rx_item_t      rx_pending[$];
  frame_result_t results_due[$];
  int            items_queued = 0;
  int            items_taken  = 0;
  int            fail_count   = 0;
  int            cycle_count  = 0;

  // handshake bookkeeping between the monitor and the driver
  logic     in_fired  = 1'b0;
  logic     out_fired = 1'b0;
  int       in_gap    = 0;
  int       out_gap   = 0;
  bit       burst_mode = 1'b0;
  rx_item_t drive_item;

  // frame tracker: our own copy of the block's frame state
  logic [7:0]        station_copy;
  logic [CNT_W-1:0]  fr_count;
  logic [15:0]       crc_run;
  logic [15:0]       crc_lag1;
  logic [15:0]       crc_lag2;
  logic [7:0]        tail_prev;
  logic [7:0]        tail_last;
  logic [7:0]        lead_byte;
  logic [WORD_W-1:0] volt_acc;
  logic [WORD_W-1:0] curr_acc;

  // reflected crc-16 over one byte, lsb first
  function automatic logic [15:0] crc16_fold(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] r;
    r = acc ^ {8'h00, b};
    repeat (8) r = (r >> 1) ^ (r[0] ? CRC_POLY : 16'h0000);
    return r;
  endfunction

  function automatic void clear_frame();
    fr_count  = '0;
    crc_run   = CRC_INIT;
    crc_lag1  = CRC_INIT;
    crc_lag2  = CRC_INIT;
    tail_prev = 8'h00;
    tail_last = 8'h00;
    lead_byte = 8'h00;
    volt_acc  = '0;
    curr_acc  = '0;
  endfunction

  // advance the frame tracker by one accepted transaction
  function automatic void track_transaction(input action_t act, input logic [7:0] b);
    frame_result_t res;
    if (act == ACT_BYTE) begin
      // bytes past the cap touch nothing, not even the crc history
      if (fr_count < MAX_LEN) begin
        if (fr_count == 0) lead_byte = b;
        if (fr_count >= 3 && fr_count <= 6)
          volt_acc[8*(6-fr_count) +: 8] = b;
        else if (fr_count >= 7 && fr_count <= 10)
          curr_acc[8*(10-fr_count) +: 8] = b;
        crc_lag2  = crc_lag1;
        crc_lag1  = crc_run;
        crc_run   = crc16_fold(crc_run, b);
        tail_prev = tail_last;
        tail_last = b;
        fr_count  = fr_count + 1'b1;
      end
    end else begin
      // line idle: the crc two bytes back must equal the last two bytes, low byte first
      res.length   = FRAME_LEN_W'(fr_count);
      res.addr_ok  = (fr_count >= 1) &&
                     (lead_byte == station_copy || lead_byte == BROADCAST_ADDR);
      res.crc_ok   = (fr_count >= 2) && (tail_prev == crc_lag2[7:0]) &&
                     (tail_last == crc_lag2[15:8]);
      res.accepted = res.addr_ok && res.crc_ok;
      res.voltage  = res.accepted ? volt_acc : '0;
      res.current  = res.accepted ? curr_acc : '0;
      results_due.push_back(res);
      clear_frame();
    end
  endfunction

  // compare one accepted result transaction against the oldest expectation
  task automatic check_result();
    frame_result_t exp_res;
    if (results_due.size() == 0) begin
      $error("result transaction with no frame pending: length %0d", out_ch.frame_length);
      fail_count++;
    end else begin
      exp_res = results_due.pop_front();
      if (out_ch.frame_length !== exp_res.length) begin
        $error("frame_length: expected %0d, got %0d", exp_res.length, out_ch.frame_length);
        fail_count++;
      end
      if (out_ch.address_ok !== exp_res.addr_ok) begin
        $error("address_ok: expected %0d, got %0d", exp_res.addr_ok, out_ch.address_ok);
        fail_count++;
      end
      if (out_ch.check_ok !== exp_res.crc_ok) begin
        $error("check_ok: expected %0d, got %0d", exp_res.crc_ok, out_ch.check_ok);
        fail_count++;
      end
      if (out_ch.frame_accepted !== exp_res.accepted) begin
        $error("frame_accepted: expected %0d, got %0d", exp_res.accepted,
               out_ch.frame_accepted);
        fail_count++;
      end
      if (out_ch.voltage_word !== exp_res.voltage) begin
        $error("voltage_word: expected %h, got %h", exp_res.voltage, out_ch.voltage_word);
        fail_count++;
      end
      if (out_ch.current_word !== exp_res.current) begin
        $error("current_word: expected %h, got %h", exp_res.current, out_ch.current_word);
        fail_count++;
      end
    end
  endtask

  // idle length: mostly none or short, now and then long, none at all in burst stretches
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (burst_mode || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // monitor: sample both channels at the rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      in_fired  <= 1'b0;
      out_fired <= 1'b0;
    end else begin
      in_fired  <= in_ch.valid && in_ch.ready;
      out_fired <= out_ch.valid && out_ch.ready;
      // a result can never belong to an idle marker taken at this same edge,
      // so checking before tracking is safe
      if (out_ch.valid && out_ch.ready) check_result();
      if (in_ch.valid && in_ch.ready) begin
        track_transaction(action_t'(in_ch.action), in_ch.rx_byte);
        items_taken++;
      end
    end
  end

  // driver: all channel inputs change at the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid  <= 1'b0;
      out_ch.ready <= 1'b0;
    end else begin
      if ($urandom_range(0, 149) == 0) burst_mode = !burst_mode;
      // input side: hold an offered transaction until it is taken
      if (!(in_ch.valid && !in_fired)) begin
        if (in_gap > 0) begin
          in_gap--;
          in_ch.valid <= 1'b0;
        end else if (rx_pending.size() > 0) begin
          drive_item = rx_pending.pop_front();
          in_ch.action  <= drive_item.act;
          in_ch.rx_byte <= drive_item.data;
          in_ch.valid   <= 1'b1;
          in_gap = pick_gap();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
      // result side: stall after a transaction and sometimes out of the blue
      if (out_fired || (out_gap == 0 && $urandom_range(0, 9) == 0)) out_gap = pick_gap();
      if (out_gap > 0) begin
        out_gap--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic push_item(input action_t act, input logic [7:0] b);
    rx_item_t it;
    it.act  = act;
    it.data = b;
    rx_pending.push_back(it);
    items_queued++;
  endtask

  // bytes of one frame followed by the idle marker that ends it
  task automatic send_frame(input byte_q_t body);
    foreach (body[i]) push_item(ACT_BYTE, body[i]);
    push_item(ACT_IDLE, 8'h00);
  endtask

  // append the crc, low byte first
  task automatic append_crc(ref byte_q_t body);
    logic [15:0] c;
    c = CRC_INIT;
    foreach (body[i]) c = crc16_fold(c, body[i]);
    body.push_back(c[7:0]);
    body.push_back(c[15:8]);
  endtask

  // one random frame: mostly well formed, some broken, overlong, noisy or empty
  task automatic gen_frame();
    byte_q_t body;
    int      kind;
    int      n;
    int      r;
    int      pos;
    logic [7:0] addr;
    kind = $urandom_range(0, 99);
    body.delete();
    if (kind < 84) begin
      r = $urandom_range(0, 9);
      if (kind < 4) n = MAX_LEN - 2;
      else if (r < 5) n = 11;
      else if (r < 9) n = $urandom_range(0, 12);
      else n = $urandom_range(13, 30);
      r = $urandom_range(0, 9);
      if (r < 5) addr = station_copy;
      else if (r < 7) addr = BROADCAST_ADDR;
      else addr = 8'($urandom_range(0, 255));
      for (int i = 0; i < n; i++) begin
        if (i == 0) body.push_back(addr);
        else if (i == 1 && $urandom_range(0, 1) == 1) body.push_back(8'h03);
        else body.push_back(8'($urandom_range(0, 255)));
      end
      append_crc(body);
      // overlong: trailing bytes past the cap must be dropped
      if (kind < 4) begin
        repeat ($urandom_range(1, 16)) body.push_back(8'($urandom_range(0, 255)));
      end
      // broken: flip one bit anywhere, crc bytes included
      if (kind >= 70) begin
        pos = $urandom_range(0, body.size() - 1);
        body[pos] = body[pos] ^ (8'h01 << $urandom_range(0, 7));
      end
    end else if (kind < 95) begin
      repeat ($urandom_range(0, 14)) body.push_back(8'($urandom_range(0, 255)));
    end
    send_frame(body);
  endtask

  // write station_id over apb, then read it back
  task automatic set_station_id(input logic [7:0] v);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_STATION_ID, 2'b00};
    pwdata  <= {24'h000000, v};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    station_copy = v;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[7:0] !== station_copy) begin
      $error("station_id readback: expected %h, got %h", station_copy, prdata[7:0]);
      fail_count++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // wait until every queued transaction is taken and every result is back
  task automatic wait_drained();
    while (items_taken != items_queued || results_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    byte_q_t    body;
    logic [7:0] phase_station[5];

    // every input known from time zero
    rst_n         = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_ch.valid   = 1'b0;
    in_ch.action  = ACT_BYTE;
    in_ch.rx_byte = 8'h00;
    out_ch.ready  = 1'b0;
    station_copy  = STATION_ID_RST;
    clear_frame();

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part with station_id at its reset value
    // empty frame: idle with no bytes, every field zero
    body.delete();
    send_frame(body);
    // single byte for this station: short frame, crc check must fail
    body.delete();
    body.push_back(STATION_ID_RST);
    send_frame(body);
    // full reading frame with voltage all ones and current all zeros
    body.delete();
    body.push_back(STATION_ID_RST);
    body.push_back(8'h03);
    body.push_back(8'h08);
    repeat (4) body.push_back(8'hFF);
    repeat (4) body.push_back(8'h00);
    append_crc(body);
    send_frame(body);
    // just a crc of nothing: check passes, foreign address, words too short
    body.delete();
    append_crc(body);
    send_frame(body);
    // broadcast address with a valid crc
    body.delete();
    body.push_back(BROADCAST_ADDR);
    append_crc(body);
    send_frame(body);
    wait_drained();

    // random phases, each under its own station_id, extremes included
    phase_station[0] = 8'hFF;
    phase_station[1] = BROADCAST_ADDR;
    phase_station[2] = 8'($urandom_range(0, 255));
    phase_station[3] = 8'h80;
    phase_station[4] = STATION_ID_RST;
    foreach (phase_station[p]) begin
      set_station_id(phase_station[p]);
      // phases always end on an idle marker, so no frame straddles a write
      for (int target = items_queued + PHASE_ITEMS; items_queued < target; )
        gen_frame();
      wait_drained();
    end

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
